// File: rtl/arc_pkg.sv
// Shared types and constants of the analog range calibrator.
package arc_pkg;

  localparam int FUNC_W    = 2;
  localparam int CHAN_W    = 3;
  localparam int SAMPLE_W  = 11;
  localparam int PHASE_W   = 3;
  localparam int SPAN_W    = 12;
  localparam int MASK_W    = 7;
  localparam int VAL_W     = 16;

  // event codes
  localparam logic [FUNC_W-1:0] FN_NONE    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_RESTART = 2'd1;
  localparam logic [FUNC_W-1:0] FN_ADVANCE = 2'd2;

  // calibration phases
  localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_MID  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_MOVE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SAVE = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE = 3'd4;

  localparam logic signed [VAL_W-1:0] LOW_RESET  = 16'sd15000;
  localparam logic signed [VAL_W-1:0] HIGH_RESET = -16'sd15000;
  localparam logic [VAL_W:0]          RANGE_MIN  = 17'd50;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0]       phase;
    logic                     cal_valid;
    logic [CHAN_W-1:0]        cal_channel;
    logic [SAMPLE_W-1:0]      cal_mid;
    logic signed [SPAN_W-1:0] span_low;
    logic signed [SPAN_W-1:0] span_high;
    logic                     save_request;
  } out_item_t;

  // one channel's tracked values as kept in memory
  typedef struct packed {
    logic signed [VAL_W-1:0] low;
    logic signed [VAL_W-1:0] high;
    logic signed [VAL_W-1:0] mid;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{low: LOW_RESET, high: HIGH_RESET, mid: 16'sd0};

endpackage

// File: rtl/arc_stream_if.sv
// Valid/ready channel carrying one payload per request.
interface arc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/analog_range_calibrator.sv
// Top level: per-channel min/max/mid tracking and calibration phase control.
//
//   channel   dir  payload                                  request when
//   samples   in   func, channel, sample                    valid & ready
//   results   out  phase, cal_*, span_low/high, save_req    valid & ready
//   cfg       in   free_pot_mask                            valid & ready
//
// One item per cycle sustained while results is not stalled; results.valid is registered, after stages 1, 2 and 3.
// Stage 1 reads the channel entry from the RAM, stage 2 does the read-modify-write
// and phase update, stage 3 scales the spans with a constant reciprocal multiply.
// A same-channel write from the previous item is forwarded around the RAM.
// Reset is synchronous; per-entry valid bits stand in for the reset values, no sweep.
// A stall on results holds the pipeline; samples.ready drops only with all three stages full.
module analog_range_calibrator #(
  parameter int NUM_CHANNELS      = 7,
  parameter int SAMPLE_BITS       = 11,
  parameter int TOLERANCE_DIVISOR = 64
) (
  input  logic         clk,
  input  logic         rst,
  arc_stream_if.sink   samples,
  arc_stream_if.source results,
  arc_stream_if.sink   cfg
);

  localparam int AW         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ENTRY_W    = $bits(arc_pkg::entry_t);
  localparam int MAG_BITS   = arc_pkg::VAL_W + 1;
  localparam int LOG_D      = $clog2(TOLERANCE_DIVISOR);
  localparam int SHIFT      = MAG_BITS + LOG_D;
  localparam int RECIP_BITS = MAG_BITS + 2;
  localparam int PROD_BITS  = MAG_BITS + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'((2**SHIFT + TOLERANCE_DIVISOR - 1) / TOLERANCE_DIVISOR);
  localparam logic [arc_pkg::SAMPLE_W-1:0] SMASK = arc_pkg::SAMPLE_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [arc_pkg::CHAN_W+1:0]   NCH   = (arc_pkg::CHAN_W + 2)'(NUM_CHANNELS);

  // configuration
  logic [arc_pkg::MASK_W-1:0] free_pot_mask;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_pot_mask <= '0;
    end else if (cfg.valid) begin
      free_pot_mask <= cfg.payload;
    end
  end

  // pipeline handshake
  logic s1_valid, s2_valid, out_valid;
  logic out_free, s2_free, s1_free, s1_adv, in_accept;

  assign out_free  = !out_valid || results.ready;
  assign s2_free   = !s2_valid || out_free;
  assign s1_adv    = s1_valid && s2_free;
  assign s1_free   = !s1_valid || s2_free;
  assign in_accept = samples.valid && s1_free;
  assign samples.ready = s1_free;

  // stage 1: request registered, RAM read in flight
  arc_pkg::in_item_t s1_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item <= samples.payload;
    end
  end

  logic [AW-1:0]       ram_raddr, ram_waddr;
  logic                ram_we;
  logic [ENTRY_W-1:0]  ram_rdata;
  arc_pkg::entry_t     wr_entry;

  assign ram_raddr = AW'(samples.payload.channel);

  arc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_CHANNELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (in_accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // bypass of the last write, valid bits per entry
  logic                    fwd_valid;
  logic [AW-1:0]           fwd_addr;
  arc_pkg::entry_t         fwd_data;
  logic [NUM_CHANNELS-1:0] entry_valid;
  logic [arc_pkg::PHASE_W-1:0] phase;

  // stage 2 compute
  logic                            s1_ok, s1_free_pot, s1_vbit, s1_cal, s1_save;
  logic [AW-1:0]                   s1_addr;
  arc_pkg::entry_t                 cur;
  logic signed [arc_pkg::VAL_W-1:0] s16, lo1, hi1, mid1, avg;
  logic signed [arc_pkg::VAL_W:0]   lo1x, hi1x, mid1x, sum, d, vl, vh;
  logic [arc_pkg::VAL_W:0]          absd;
  logic [arc_pkg::PHASE_W-1:0]      ph_ev, phase_next;
  logic [arc_pkg::MASK_W:0]         mask_ext;

  always_comb begin
    s1_addr     = AW'(s1_item.channel);
    s1_ok       = {2'b00, s1_item.channel} < NCH;
    s1_vbit     = s1_ok && entry_valid[s1_addr];
    mask_ext    = {1'b0, free_pot_mask};
    s1_free_pot = mask_ext[s1_item.channel];

    if (fwd_valid && fwd_addr == s1_addr) begin
      cur = fwd_data;
    end else if (s1_vbit) begin
      cur = arc_pkg::entry_t'(ram_rdata);
    end else begin
      cur = arc_pkg::ENTRY_RESET;
    end

    s16  = {5'b00000, s1_item.sample & SMASK};
    lo1  = (s16 < cur.low)  ? s16 : cur.low;
    hi1  = (s16 > cur.high) ? s16 : cur.high;
    lo1x = {lo1[arc_pkg::VAL_W-1], lo1};
    hi1x = {hi1[arc_pkg::VAL_W-1], hi1};
    sum  = lo1x + hi1x;
    // halve, truncating toward zero
    avg  = arc_pkg::VAL_W'((sum + {16'd0, sum[arc_pkg::VAL_W]}) >>> 1);
    mid1 = s1_free_pot ? avg : cur.mid;
    mid1x = {mid1[arc_pkg::VAL_W-1], mid1};

    wr_entry = '{low: lo1, high: hi1, mid: mid1};

    case (s1_item.func)
      arc_pkg::FN_RESTART: ph_ev = arc_pkg::PH_IDLE;
      arc_pkg::FN_ADVANCE: ph_ev = phase + 3'd1;
      default:             ph_ev = phase;
    endcase

    d    = lo1x - hi1x;
    absd = d[arc_pkg::VAL_W] ? unsigned'(-d) : unsigned'(d);
    vl   = mid1x - lo1x;
    vh   = hi1x - mid1x;

    phase_next = ph_ev;
    s1_cal     = 1'b0;
    s1_save    = 1'b0;
    case (ph_ev)
      arc_pkg::PH_IDLE: begin
      end
      arc_pkg::PH_MID: begin
        wr_entry = '{low: arc_pkg::LOW_RESET, high: arc_pkg::HIGH_RESET, mid: s16};
      end
      arc_pkg::PH_MOVE: begin
        s1_cal = s1_ok && (absd > arc_pkg::RANGE_MIN);
      end
      arc_pkg::PH_SAVE: begin
        s1_save    = 1'b1;
        phase_next = arc_pkg::PH_DONE;
      end
      default: begin
        phase_next = arc_pkg::PH_IDLE;
      end
    endcase
  end

  assign ram_we    = s1_adv && s1_ok;
  assign ram_waddr = s1_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= arc_pkg::PH_IDLE;
      fwd_valid   <= 1'b0;
      entry_valid <= '0;
    end else if (s1_adv) begin
      phase <= phase_next;
      if (s1_ok) begin
        fwd_valid            <= 1'b1;
        entry_valid[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr <= s1_addr;
      fwd_data <= wr_entry;
    end
  end

  // stage 3 registers: result fields and span magnitudes
  logic [arc_pkg::PHASE_W-1:0]  s2_phase;
  logic                         s2_cal, s2_save, s2_neg_l, s2_neg_h;
  logic [arc_pkg::CHAN_W-1:0]   s2_ch;
  logic [arc_pkg::SAMPLE_W-1:0] s2_mid;
  logic [MAG_BITS-1:0]          s2_mag_l, s2_mag_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_phase <= phase_next;
      s2_cal   <= s1_cal;
      s2_save  <= s1_save;
      s2_ch    <= s1_cal ? s1_item.channel : '0;
      s2_mid   <= s1_cal ? mid1[arc_pkg::SAMPLE_W-1:0] : '0;
      s2_neg_l <= s1_cal && vl[arc_pkg::VAL_W];
      s2_neg_h <= s1_cal && vh[arc_pkg::VAL_W];
      s2_mag_l <= !s1_cal ? '0 : (vl[arc_pkg::VAL_W] ? unsigned'(-vl) : unsigned'(vl));
      s2_mag_h <= !s1_cal ? '0 : (vh[arc_pkg::VAL_W] ? unsigned'(-vh) : unsigned'(vh));
    end
  end

  // span shrink: v - v/D via exact reciprocal on the magnitude
  logic [PROD_BITS-1:0]         prod_l, prod_h;
  logic [MAG_BITS-1:0]          q_l, q_h, r_l, r_h;
  logic [MAG_BITS-1:0]          sp_l, sp_h;
  arc_pkg::out_item_t           out_next, out_item;

  always_comb begin
    prod_l = {{RECIP_BITS{1'b0}}, s2_mag_l} * {{MAG_BITS{1'b0}}, RECIP};
    prod_h = {{RECIP_BITS{1'b0}}, s2_mag_h} * {{MAG_BITS{1'b0}}, RECIP};
    q_l    = MAG_BITS'(prod_l >> SHIFT);
    q_h    = MAG_BITS'(prod_h >> SHIFT);
    r_l    = s2_mag_l - q_l;
    r_h    = s2_mag_h - q_h;
    sp_l   = s2_neg_l ? -r_l : r_l;
    sp_h   = s2_neg_h ? -r_h : r_h;

    out_next.phase        = s2_phase;
    out_next.cal_valid    = s2_cal;
    out_next.cal_channel  = s2_ch;
    out_next.cal_mid      = s2_mid;
    out_next.span_low     = sp_l[arc_pkg::SPAN_W-1:0];
    out_next.span_high    = sp_h[arc_pkg::SPAN_W-1:0];
    out_next.save_request = s2_save;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      out_item <= out_next;
    end
  end

  assign results.valid   = out_valid;
  assign results.payload = out_item;

  // checks
  a_save_done: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.payload.save_request |-> results.payload.phase == arc_pkg::PH_DONE)
    else $error("save request outside done phase");

  a_cal_move: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.payload.cal_valid |-> results.payload.phase == arc_pkg::PH_MOVE)
    else $error("calibration values outside moving phase");

  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> s1_valid && s1_ok)
    else $error("store write without an in-range request");

  a_phase_done: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_save |=> phase == arc_pkg::PH_DONE)
    else $error("phase not done after save");

  a_bypass: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> fwd_valid && entry_valid[fwd_addr])
    else $error("bypass not loaded after store write");

endmodule

// File: rtl/arc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sim/arc_checker.sv
// Checker for the analog range calibrator: tracks the calibration state and compares results.
`timescale 1ns / 100ps

module arc_checker #(
  parameter int NUM_CH  = 7,
  parameter int DIVISOR = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic                       req_ready,
  input  arc_pkg::in_item_t          req_item,
  input  logic                       res_valid,
  input  logic                       res_ready,
  input  arc_pkg::out_item_t         res_item,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [arc_pkg::MASK_W-1:0] cfg_mask,
  output int                         fail_count
);

  int                           lo_val [NUM_CH];
  int                           hi_val [NUM_CH];
  int                           mid_val[NUM_CH];
  logic [arc_pkg::PHASE_W-1:0]  cal_ph;
  logic [arc_pkg::MASK_W-1:0]   pot_mask;
  arc_pkg::out_item_t           pending_cal[$];
  int                           n_bad = 0;

  function automatic int trim_span(int v);
    return v - v / DIVISOR;
  endfunction

  // one calibration step; updates the tracked state
  function automatic arc_pkg::out_item_t calibrate_step(arc_pkg::in_item_t req);
    arc_pkg::out_item_t r;
    logic [arc_pkg::CHAN_W-1:0] ch;
    int s;
    int d;
    int m;
    bit in_range;
    r = '0;
    ch = req.channel;
    s = int'(req.sample);
    in_range = ch < NUM_CH;
    if (in_range) begin
      if (s < lo_val[ch]) lo_val[ch] = s;
      if (s > hi_val[ch]) hi_val[ch] = s;
      if (pot_mask[ch]) mid_val[ch] = (hi_val[ch] + lo_val[ch]) / 2;
    end
    case (req.func)
      arc_pkg::FN_RESTART: cal_ph = arc_pkg::PH_IDLE;
      arc_pkg::FN_ADVANCE: cal_ph = cal_ph + 1'b1;
      default: ;
    endcase
    case (cal_ph)
      arc_pkg::PH_IDLE: ;
      arc_pkg::PH_MID: begin
        if (in_range) begin
          lo_val[ch]  = int'(arc_pkg::LOW_RESET);
          hi_val[ch]  = int'(arc_pkg::HIGH_RESET);
          mid_val[ch] = s;
        end
      end
      arc_pkg::PH_MOVE: begin
        if (in_range) begin
          d = lo_val[ch] - hi_val[ch];
          if (d < 0) d = -d;
          if (d > int'(arc_pkg::RANGE_MIN)) begin
            m = mid_val[ch];
            r.cal_valid   = 1'b1;
            r.cal_channel = ch;
            r.cal_mid     = arc_pkg::SAMPLE_W'(m);
            r.span_low    = arc_pkg::SPAN_W'(trim_span(m - lo_val[ch]));
            r.span_high   = arc_pkg::SPAN_W'(trim_span(hi_val[ch] - m));
          end
        end
      end
      arc_pkg::PH_SAVE: begin
        r.save_request = 1'b1;
        cal_ph = arc_pkg::PH_DONE;
      end
      default: cal_ph = arc_pkg::PH_IDLE;  // done or beyond: back to idle
    endcase
    r.phase = cal_ph;
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [15:0] want,
                                      logic signed [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      n_bad++;
    end
  endfunction

  always @(posedge clk) begin
    arc_pkg::out_item_t want;
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        lo_val[i]  = int'(arc_pkg::LOW_RESET);
        hi_val[i]  = int'(arc_pkg::HIGH_RESET);
        mid_val[i] = 0;
      end
      cal_ph   = arc_pkg::PH_IDLE;
      pot_mask = '0;
      pending_cal.delete();
    end else begin
      if (cfg_valid && cfg_ready) pot_mask = cfg_mask;
      if (req_valid && req_ready) pending_cal.push_back(calibrate_step(req_item));
      if (res_valid && res_ready) begin
        if (pending_cal.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          n_bad++;
        end else begin
          want = pending_cal.pop_front();
          check_field("phase",        want.phase,        res_item.phase);
          check_field("cal_valid",    want.cal_valid,    res_item.cal_valid);
          check_field("cal_channel",  want.cal_channel,  res_item.cal_channel);
          check_field("cal_mid",      want.cal_mid,      res_item.cal_mid);
          check_field("span_low",     want.span_low,     res_item.span_low);
          check_field("span_high",    want.span_high,    res_item.span_high);
          check_field("save_request", want.save_request, res_item.save_request);
        end
      end
    end
    // outstanding expectations count as failures once the run has drained
    fail_count = n_bad + pending_cal.size();
  end

endmodule

// File: sim/analog_range_calibrator_test.sv
// Top of the analog range calibrator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module analog_range_calibrator_test;

  localparam int NUM_CH      = 7;
  localparam int DIVISOR     = 64;
  localparam int NUM_ITEMS   = 900;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [arc_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   n_req = 0;
  int   n_res = 0;
  int   n_items = 0;
  int   cycle_count = 0;
  bit   tx_quiet = 1'b0;
  bit   rx_quiet = 1'b0;

  always #5 clk = ~clk;

  arc_stream_if #(.T(arc_pkg::in_item_t))             sample_bus ();
  arc_stream_if #(.T(arc_pkg::out_item_t))            result_bus ();
  arc_stream_if #(.T(logic [arc_pkg::MASK_W-1:0]))    cfg_bus ();

  analog_range_calibrator #(
    .NUM_CHANNELS      (NUM_CH),
    .SAMPLE_BITS       (arc_pkg::SAMPLE_W),
    .TOLERANCE_DIVISOR (DIVISOR)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_bus),
    .results (result_bus),
    .cfg     (cfg_bus)
  );

  arc_checker #(
    .NUM_CH  (NUM_CH),
    .DIVISOR (DIVISOR)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (sample_bus.valid),
    .req_ready  (sample_bus.ready),
    .req_item   (sample_bus.payload),
    .res_valid  (result_bus.valid),
    .res_ready  (result_bus.ready),
    .res_item   (result_bus.payload),
    .cfg_valid  (cfg_bus.valid),
    .cfg_ready  (cfg_bus.ready),
    .cfg_mask   (cfg_bus.payload),
    .fail_count (fail_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      n_req <= 0;
      n_res <= 0;
    end else begin
      if (sample_bus.valid && sample_bus.ready) n_req <= n_req + 1;
      if (result_bus.valid && result_bus.ready) n_res <= n_res + 1;
    end
  end

  // result side: random stall before each result, with stall-free stretches
  initial begin
    int stall;
    int n_taken;
    n_taken = 0;
    result_bus.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (n_taken % 24 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      stall = rx_quiet ? 0 : $urandom_range(0, 19);
      repeat (stall) begin
        @(negedge clk);
        result_bus.ready <= 1'b0;
      end
      @(negedge clk);
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!(result_bus.valid && result_bus.ready));
      n_taken++;
    end
  end

  task automatic send_sample(input logic [arc_pkg::FUNC_W-1:0] fn,
                             input logic [arc_pkg::CHAN_W-1:0] ch,
                             input logic [arc_pkg::SAMPLE_W-1:0] smp);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk);
      sample_bus.valid <= 1'b0;
    end
    @(negedge clk);
    sample_bus.valid   <= 1'b1;
    sample_bus.payload <= '{func: fn, channel: ch, sample: smp};
    do @(posedge clk); while (!(sample_bus.valid && sample_bus.ready));
    n_items++;
  endtask

  task automatic drain_requests();
    @(negedge clk);
    sample_bus.valid <= 1'b0;
    while (n_res < n_req) @(negedge clk);
  endtask

  // mask is written only with nothing in flight
  task automatic write_pot_mask(input logic [arc_pkg::MASK_W-1:0] mask);
    drain_requests();
    @(negedge clk);
    cfg_bus.valid   <= 1'b1;
    cfg_bus.payload <= mask;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [arc_pkg::CHAN_W-1:0] draw_channel();
    if ($urandom_range(0, 9) == 0) return arc_pkg::CHAN_W'(NUM_CH);
    return arc_pkg::CHAN_W'($urandom_range(0, NUM_CH - 1));
  endfunction

  function automatic logic [arc_pkg::SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return arc_pkg::SAMPLE_W'($urandom_range(0, (1 << arc_pkg::SAMPLE_W) - 1));
    endcase
  endfunction

  // optional restart, capture mids, sweep, save or restart, back to idle
  task automatic run_calibration();
    bit narrow;
    int base;
    if ($urandom_range(0, 1)) send_sample(arc_pkg::FN_RESTART, draw_channel(), draw_sample());
    send_sample(arc_pkg::FN_ADVANCE, draw_channel(), draw_sample());
    repeat ($urandom_range(0, 8)) send_sample(arc_pkg::FN_NONE, draw_channel(), draw_sample());
    send_sample(arc_pkg::FN_ADVANCE, draw_channel(), draw_sample());
    narrow = ($urandom_range(0, 3) == 0);
    base = $urandom_range(0, 2000);
    repeat ($urandom_range(5, 40)) begin
      send_sample(($urandom_range(0, 19) == 0) ? FN_UNUSED : arc_pkg::FN_NONE, draw_channel(),
                  narrow ? arc_pkg::SAMPLE_W'(base + $urandom_range(0, 40)) : draw_sample());
    end
    if ($urandom_range(0, 9) == 0) begin
      send_sample(arc_pkg::FN_RESTART, draw_channel(), draw_sample());
    end else begin
      send_sample(arc_pkg::FN_ADVANCE, draw_channel(), draw_sample());
      send_sample($urandom_range(0, 1) ? arc_pkg::FN_ADVANCE : arc_pkg::FN_NONE,
                  draw_channel(), draw_sample());
    end
  endtask

  initial begin
    rst = 1'b1;
    sample_bus.valid   = 1'b0;
    sample_bus.payload = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.payload    = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    write_pot_mask('1);
    send_sample(arc_pkg::FN_NONE,    3'd0, '0);
    send_sample(arc_pkg::FN_NONE,    3'd0, '1);
    send_sample(FN_UNUSED,           3'd1, 11'd100);
    send_sample(arc_pkg::FN_NONE,    arc_pkg::CHAN_W'(NUM_CH), 11'd555);
    send_sample(arc_pkg::FN_ADVANCE, 3'd0, 11'd1024);
    send_sample(arc_pkg::FN_NONE,    3'd1, '0);
    send_sample(arc_pkg::FN_NONE,    3'd2, '1);
    send_sample(arc_pkg::FN_NONE,    arc_pkg::CHAN_W'(NUM_CH), 11'd300);
    send_sample(arc_pkg::FN_ADVANCE, arc_pkg::CHAN_W'(NUM_CH), '1);
    // range of exactly 50 gives nothing, 51 gives values
    send_sample(arc_pkg::FN_NONE,    3'd0, 11'd1000);
    send_sample(arc_pkg::FN_NONE,    3'd0, 11'd1050);
    send_sample(arc_pkg::FN_NONE,    3'd0, 11'd1051);
    send_sample(arc_pkg::FN_NONE,    3'd0, '0);
    send_sample(arc_pkg::FN_NONE,    3'd0, '1);
    send_sample(arc_pkg::FN_NONE,    3'd1, '1);
    send_sample(FN_UNUSED,           3'd1, 11'd3);
    send_sample(arc_pkg::FN_ADVANCE, 3'd1, 11'd5);
    send_sample(arc_pkg::FN_NONE,    3'd2, 11'd9);
    // advance through every phase, past done
    repeat (4) send_sample(arc_pkg::FN_ADVANCE, 3'd3, draw_sample());
    send_sample(arc_pkg::FN_ADVANCE, 3'd5, 11'd77);
    send_sample(arc_pkg::FN_RESTART, 3'd4, 11'd1);
    send_sample(arc_pkg::FN_RESTART, 3'd6, 11'd2046);

    write_pot_mask('0);
    while (n_items < NUM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 2))
          0: write_pot_mask('0);
          1: write_pot_mask('1);
          default: write_pot_mask(arc_pkg::MASK_W'($urandom));
        endcase
      end
      tx_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        run_calibration();
      end else begin
        repeat ($urandom_range(3, 15))
          send_sample(arc_pkg::FUNC_W'($urandom_range(0, 3)), draw_channel(), draw_sample());
      end
    end

    drain_requests();
    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
